// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked implication checks with a synchronous reset guard
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication check failed");

`endif

// ----- sv/lrc_pkg.sv -----
// ----------------------------------------------------------------------------
// lrc_pkg
// shared widths, types and codes of the lru row cache controller
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

   localparam int ROW_W      = 16;
   localparam int SLOT_OUT_W = 6;
   localparam int CAP_W      = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // outcome of one lookup, before the fill flag is added
   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  evict_valid;
      logic [ROW_W-1:0]      evict_row;
   } lrc_lookup_result_type;

   // mark a row as written back
   typedef struct packed {
      logic             set_en;
      logic [ROW_W-1:0] set_row;
   } lrc_wb_set_type;

   // written-back map clearing sequencer
   typedef enum logic {
      CLR_SWEEP,
      CLR_READY
   } lrc_clr_state_type;

endpackage

`default_nettype wire

// ----- sv/lrc_req_if.sv -----
// ----------------------------------------------------------------------------
// lrc_req_if
// request channel: one row access per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface lrc_req_if import lrc_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;

   modport source (output valid, output row_index, input ready);
   modport sink   (input valid, input row_index, output ready);

endinterface

`default_nettype wire

// ----- sv/lrc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lrc_rsp_if
// response channel: lookup outcome of one request
// ----------------------------------------------------------------------------
`default_nettype none

interface lrc_rsp_if import lrc_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [SLOT_OUT_W-1:0] slot;
   logic                  evict_valid;
   logic [ROW_W-1:0]      evict_row;
   logic                  fill_needed;

   modport source (output valid, output hit, output slot, output evict_valid,
                   output evict_row, output fill_needed, input ready);
   modport sink   (input valid, input hit, input slot, input evict_valid,
                   input evict_row, input fill_needed, output ready);

endinterface

`default_nettype wire

// ----- sv/lrc_wb_map.sv -----
// ----------------------------------------------------------------------------
// lrc_wb_map
// written-back bitmap: one bit per row, cleared by a sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_wb_map import lrc_pkg::*; #(
   parameter int MAX_ROWS = 65536
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [ROW_W-1:0] rd_row,
   input  lrc_wb_set_type   wb_set,
   output logic             written_back,
   output logic             map_ready
);

   localparam int ROW_SPAN = 1 << ROW_W;
   localparam int WB_DEPTH = (MAX_ROWS < ROW_SPAN) ? MAX_ROWS : ROW_SPAN;
   localparam int AW       = $clog2(WB_DEPTH);

   localparam logic [ROW_W:0]  WB_LIMIT  = (ROW_W+1)'(WB_DEPTH);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(WB_DEPTH - 1);

   logic              wb_mem [WB_DEPTH];

   lrc_clr_state_type clr_state_ff, clr_state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;

   logic              rd_data_ff;
   logic [ROW_W-1:0]  rd_row_ff;
   logic              last_valid_ff, last_valid_in;
   logic [ROW_W-1:0]  last_row_ff, last_row_in;

   logic              set_in_range;
   logic              rd_in_range;

   assign set_in_range = {1'b0, wb_set.set_row} < WB_LIMIT;
   assign rd_in_range  = {1'b0, rd_row_ff} < WB_LIMIT;

   // clearing sweep
   always_comb begin
      clr_state_in = clr_state_ff;
      clr_addr_in  = clr_addr_ff;
      unique case (clr_state_ff)
         CLR_SWEEP: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               clr_state_in = CLR_READY;
            end
         end
         CLR_READY: begin
            clr_addr_in = clr_addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_state_ff <= CLR_SWEEP;
         clr_addr_ff  <= '0;
      end else begin
         clr_state_ff <= clr_state_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   assign map_ready = (clr_state_ff == CLR_READY);

   // bit store
   always_ff @(posedge clock) begin
      if (clr_state_ff == CLR_SWEEP) begin
         wb_mem[clr_addr_ff] <= 1'b0;
      end else if (wb_set.set_en && set_in_range) begin
         wb_mem[wb_set.set_row[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
         rd_data_ff <= wb_mem[rd_row[AW-1:0]];
         rd_row_ff  <= rd_row;
      end
   end

   // last row marked, covers a read taken in the same cycle as the write
   always_comb begin
      last_valid_in = last_valid_ff;
      last_row_in   = last_row_ff;
      if (wb_set.set_en && set_in_range) begin
         last_valid_in = 1'b1;
         last_row_in   = wb_set.set_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else begin
         last_valid_ff <= last_valid_in;
      end
      last_row_ff <= last_row_in;
   end

   assign written_back = rd_in_range &&
                         (rd_data_ff || (last_valid_ff && (last_row_ff == rd_row_ff)));

endmodule

`default_nettype wire

// ----- sv/lrc_lookup.sv -----
// ----------------------------------------------------------------------------
// lrc_lookup
// slot tags, recency ranks and the hit / allocate / evict step
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_lookup import lrc_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [ROW_W-1:0]      row,
   input  logic [CAP_W-1:0]      capacity,
   output lrc_lookup_result_type result,
   output lrc_wb_set_type        wb_set
);

   localparam int SW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int MW = (CW > CAP_W) ? CW : CAP_W;

   logic [ROW_W-1:0] tag_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SW-1:0]    rank_ff [SLOTS];
   logic [SW-1:0]    rank_in [SLOTS];
   logic [CW-1:0]    count_ff, count_in;

   logic [SLOTS-1:0] match_vec;
   logic [SLOTS-1:0] victim_vec;
   logic [SLOTS-1:0] cand_vec;
   logic [SLOTS-1:0] sel_onehot;
   logic [CW-1:0]    count_less;
   logic [MW-1:0]    cap_ext;
   logic [MW-1:0]    cap_eff;
   logic             any_hit;
   logic             full;
   logic [SW-1:0]    sel_idx;
   logic [SW-1:0]    sel_rank;
   logic [ROW_W-1:0] sel_tag;
   logic [CW-1:0]    age_limit;
   logic [8:0]       slot_wide;

   assign count_less = count_ff - CW'(1);

   // parallel tag compare and victim detect (victim holds rank count-1)
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         match_vec[k]  = valid_ff[k] && (tag_ff[k] == row);
         victim_vec[k] = valid_ff[k] && (rank_ff[k] == count_less[SW-1:0]);
      end
   end

   // capacity clamp: zero acts as one, above slot count acts as slot count
   always_comb begin
      cap_ext = MW'(capacity);
      cap_eff = cap_ext;
      if (cap_ext == '0) begin
         cap_eff = MW'(1);
      end else if (cap_ext > MW'(SLOTS)) begin
         cap_eff = MW'(SLOTS);
      end
   end

   assign any_hit = |match_vec;
   assign full    = MW'(count_ff) >= cap_eff;

   assign cand_vec   = any_hit ? match_vec : (full ? victim_vec : ~valid_ff);
   assign sel_onehot = cand_vec & (~cand_vec + {{(SLOTS-1){1'b0}}, 1'b1});

   always_comb begin
      sel_idx  = '0;
      sel_rank = '0;
      sel_tag  = '0;
      for (int k = 0; k < SLOTS; k++) begin
         if (sel_onehot[k]) begin
            sel_idx  = sel_idx | SW'(k);
            sel_rank = sel_rank | rank_ff[k];
            sel_tag  = sel_tag | tag_ff[k];
         end
      end
   end

   // slots younger than the limit age by one
   always_comb begin
      if (any_hit) begin
         age_limit = CW'(sel_rank);
      end else if (full) begin
         age_limit = count_less;
      end else begin
         age_limit = count_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < SLOTS; k++) begin
         rank_in[k] = rank_ff[k];
         if (fire) begin
            if (sel_onehot[k]) begin
               valid_in[k] = 1'b1;
               rank_in[k]  = '0;
            end else if (valid_ff[k] && (CW'(rank_ff[k]) < age_limit)) begin
               rank_in[k] = rank_ff[k] + SW'(1);
            end
         end
      end
      count_in = (fire && !any_hit && !full) ? count_ff + CW'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int k = 0; k < SLOTS; k++) begin
            rank_ff[k] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int k = 0; k < SLOTS; k++) begin
            rank_ff[k] <= rank_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS; k++) begin
         if (fire && sel_onehot[k]) begin
            tag_ff[k] <= row;
         end
      end
   end

   assign slot_wide          = 9'(sel_idx);
   assign result.hit         = any_hit;
   assign result.slot        = slot_wide[SLOT_OUT_W-1:0];
   assign result.evict_valid = !any_hit && full;
   assign result.evict_row   = (!any_hit && full) ? sel_tag : '0;

   assign wb_set.set_en  = fire && !any_hit && full;
   assign wb_set.set_row = sel_tag;

endmodule

`default_nettype wire

// ----- sv/lru_row_cache_controller.sv -----
// ----------------------------------------------------------------------------
// lru_row_cache_controller
// fully associative row cache controller with lru replacement
// ----------------------------------------------------------------------------
// usage
//  - req_chan: one request per transfer carries a row index; a transfer
//    happens when valid and ready are both high at a clock edge
//  - rsp_chan: one response per request, in request order: hit, slot now
//    holding the row, eviction for write-back and the fill flag
//  - csr port: csr_write_enable writes csr_write_data into capacity; write
//    it only while no request is in flight
//  - path: a taken request is held in the request register; its lookup
//    result loads the response register when the request stage moves on
//    (request register, then response register)
//  - throughput: one request per cycle while rsp_chan is not held; tag compare
//    and rank update for all slots are combinational between the two registers
//  - reset: all slots empty, capacity 64; the written-back map is then swept
//    clear, one row a cycle, over min(MAX_ROWS, 65536) rows (65536 at the
//    default), while req_chan.ready stays low
//  - stall: when rsp_chan is held, the response register and the request
//    register both fill and req_chan.ready drops; nothing is lost
// ----------------------------------------------------------------------------
`default_nettype none

module lru_row_cache_controller import lrc_pkg::*; #(
   parameter int SLOTS    = 64,
   parameter int MAX_ROWS = 65536
) (
   input  logic             clock,
   input  logic             reset,
   lrc_req_if.sink          req_chan,
   lrc_rsp_if.source        rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

`include "assert_macros.svh"

   // capacity register
   logic [CAP_W-1:0]      capacity_ff, capacity_in;

   // request register
   logic                  s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]      s1_row_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_evict_valid_ff;
   logic [ROW_W-1:0]      rsp_evict_row_ff;
   logic                  rsp_fill_ff;

   logic                  req_accept;
   logic                  s1_fire;
   logic                  map_ready;
   logic                  written_back;
   lrc_lookup_result_type lookup_result;
   lrc_wb_set_type        wb_set;

   logic                  s1_stall;
   logic                  rsp_hit_shown;

   assign capacity_in = csr_write_enable ? csr_write_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // handshake: the request stage moves on when the response register is
   // empty or being drained this cycle
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = map_ready && (!s1_valid_ff || s1_fire);
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff <= req_chan.row_index;
      end
   end

   // tag store, recency ranks and replacement choice
   lrc_lookup #(
      .SLOTS (SLOTS)
   ) u_lookup (
      .clock    (clock),
      .reset    (reset),
      .fire     (s1_fire),
      .row      (s1_row_ff),
      .capacity (capacity_ff),
      .result   (lookup_result),
      .wb_set   (wb_set)
   );

   // written-back map, read as the request is taken so the bit is ready
   // alongside the lookup
   lrc_wb_map #(
      .MAX_ROWS (MAX_ROWS)
   ) u_wb_map (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (req_accept),
      .rd_row       (req_chan.row_index),
      .wb_set       (wb_set),
      .written_back (written_back),
      .map_ready    (map_ready)
   );

   // response register load; fill only matters on a miss
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_hit_ff         <= lookup_result.hit;
         rsp_slot_ff        <= lookup_result.slot;
         rsp_evict_valid_ff <= lookup_result.evict_valid;
         rsp_evict_row_ff   <= lookup_result.evict_row;
         rsp_fill_ff        <= !lookup_result.hit && written_back;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.slot        = rsp_slot_ff;
   assign rsp_chan.evict_valid = rsp_evict_valid_ff;
   assign rsp_chan.evict_row   = rsp_evict_row_ff;
   assign rsp_chan.fill_needed = rsp_fill_ff;

   // request stage blocked behind a held response
   assign s1_stall      = s1_valid_ff && rsp_valid_ff && !rsp_chan.ready;
   assign rsp_hit_shown = rsp_valid_ff && rsp_hit_ff;

   // a taken request always lands in the request register
   `ASSERT_NEXT(a_accept_loads_stage, clock, reset, req_accept, s1_valid_ff)

   // a held response keeps the request stage and its row in place
   `ASSERT_NEXT(a_stall_holds_stage, clock, reset, s1_stall, s1_valid_ff && $stable(s1_row_ff))

   // a hit never evicts and never asks for a fill
   `ASSERT_IMPLY(a_hit_is_clean, clock, reset, rsp_hit_shown, !rsp_evict_valid_ff && !rsp_fill_ff)

endmodule

`default_nettype wire

// ----- sim/lru_row_cache_controller_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_row_cache_controller_test
// self-checking bench for the lru row cache controller: row accesses are
// driven with random gaps and back-pressure, a shadow copy of the cache
// predicts hit, slot, eviction and fill for each request, and every response
// is compared field by field in request order
// ----------------------------------------------------------------------------

module lru_row_cache_controller_test;
   import lrc_pkg::*;

   localparam int SLOT_COUNT  = 64;
   localparam int STALL_LIMIT = 300000;  // clear sweep after reset covers 65536 rows
   localparam int HOLD_LEN    = 60;

   // expected outcome of one request, fill flag included
   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  evict_valid;
      logic [ROW_W-1:0]      evict_row;
      logic                  fill_needed;
   } row_outcome_type;

   // shadow of the cache contents plus the queue of outcomes still owed
   class row_cache_shadow_type;
      logic [CAP_W-1:0] capacity = CAP_RESET;
      logic [ROW_W-1:0] slot_tag [SLOT_COUNT];
      bit               slot_used [SLOT_COUNT];
      int               rank [SLOT_COUNT];
      int               resident = 0;
      bit [65535:0]     written_back = '0;
      row_outcome_type  outcome_q [$];
      int               failures = 0;

      function new();
         foreach (slot_used[k]) begin
            slot_used[k] = 1'b0;
            rank[k]      = 0;
            slot_tag[k]  = '0;
         end
      endfunction

      // slot s becomes most recent, valid slots younger than limit age by one
      function void make_recent(int s, int limit);
         for (int k = 0; k < SLOT_COUNT; k++)
            if (k != s && slot_used[k] && rank[k] < limit) rank[k]++;
         rank[s] = 0;
      endfunction

      function row_outcome_type access_row(logic [ROW_W-1:0] row);
         row_outcome_type r;
         int              cap;
         int              s;
         int              best;
         bit              found;
         bit              any;
         r     = '0;
         cap   = capacity;
         s     = 0;
         found = 1'b0;
         if (cap == 0) cap = 1;
         if (cap > SLOT_COUNT) cap = SLOT_COUNT;
         for (int k = 0; k < SLOT_COUNT; k++)
            if (!found && slot_used[k] && slot_tag[k] == row) begin
               s     = k;
               found = 1'b1;
            end
         if (found) begin
            r.hit = 1'b1;
            make_recent(s, rank[s]);
         end else begin
            if (resident < cap) begin
               // lowest numbered free slot
               any = 1'b0;
               for (int k = 0; k < SLOT_COUNT; k++)
                  if (!any && !slot_used[k]) begin
                     s   = k;
                     any = 1'b1;
                  end
               slot_used[s] = 1'b1;
               resident++;
               rank[s] = SLOT_COUNT;
               make_recent(s, SLOT_COUNT + 1);
            end else begin
               // evict the least recent row
               best = 0;
               any  = 1'b0;
               for (int k = 0; k < SLOT_COUNT; k++)
                  if (slot_used[k] && (!any || rank[k] > best)) begin
                     best = rank[k];
                     s    = k;
                     any  = 1'b1;
                  end
               r.evict_valid = 1'b1;
               r.evict_row   = slot_tag[s];
               written_back[slot_tag[s]] = 1'b1;
               make_recent(s, rank[s]);
            end
            slot_tag[s]   = row;
            r.fill_needed = written_back[row];
         end
         r.slot = s[SLOT_OUT_W-1:0];
         return r;
      endfunction

      function void note_request(logic [ROW_W-1:0] row);
         outcome_q.push_back(access_row(row));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(row_outcome_type got);
         row_outcome_type want;
         if (outcome_q.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
            return;
         end
         want = outcome_q.pop_front();
         compare_field("hit", want.hit, got.hit);
         compare_field("slot", want.slot, got.slot);
         compare_field("evict_valid", want.evict_valid, got.evict_valid);
         compare_field("evict_row", want.evict_row, got.evict_row);
         compare_field("fill_needed", want.fill_needed, got.fill_needed);
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_write_enable;
   logic [CAP_W-1:0] csr_write_data;

   lrc_req_if req_chan ();
   lrc_rsp_if rsp_chan ();

   lru_row_cache_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   row_cache_shadow_type shadow;

   // idle percentages for each side, changed between phases
   int req_idle_pct = 29;
   int rsp_idle_pct = 53;

   // 8 ns clock
   always begin
      #4ns clock = 1'b1;
      #4ns clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // response side: check accepted responses, drive ready with random
   // stalls, and twice hold ready low for a long stretch so that both
   // pipeline registers fill and the request side backs up
   // ---------------------------------------------------------------------
   int served         = 0;
   int hold_left      = 0;
   int last_hold_mark = -1;

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         shadow.check_response({rsp_chan.hit, rsp_chan.slot, rsp_chan.evict_valid,
                                rsp_chan.evict_row, rsp_chan.fill_needed});
         served++;
      end
      if (hold_left == 0 && (served == 250 || served == 1100) && served != last_hold_mark) begin
         hold_left      = HOLD_LEN;
         last_hold_mark = served;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog: cycles in a row with no transfer on either channel
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // offer one row access after a random gap, hold it until it is taken
   task automatic send_row(input logic [ROW_W-1:0] row);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.row_index <= row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      shadow.note_request(row);
   endtask

   // wait for every owed response, then let the pipeline go idle
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // capacity only changes while the block is empty
   task automatic set_capacity(input logic [CAP_W-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow.capacity = value;
   endtask

   // capacities of the random phases; the last one is drawn at random
   int phase_cap [10] = '{64, 1, 127, 0, 9, 64, 2, 100, 33, 0};

   initial begin
      logic [ROW_W-1:0] pool_base;
      int               cap_eff;
      int               span;
      shadow             = new();
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.row_index = '0;
      rsp_chan.ready     = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset capacity: extreme rows, a hit
      send_row(16'h0000);
      send_row(16'hFFFF);
      send_row(16'h0000);
      send_row(16'hAAAA);
      send_row(16'h5555);

      // capacity lowered below the resident count: each miss evicts one
      set_capacity(7'd2);
      send_row(16'h0001);
      send_row(16'h0002);
      send_row(16'hFFFF);  // written back earlier, so a fill
      send_row(16'h0002);

      // zero capacity behaves as one slot
      set_capacity(7'd0);
      send_row(16'h0000);
      send_row(16'h0000);
      send_row(16'h1234);

      // capacity above the slot count behaves as all slots
      set_capacity(7'd127);
      send_row(16'h8000);
      send_row(16'h7FFF);
      send_row(16'h1234);

      // random phases: mostly a working set a little larger than the
      // capacity, so hits, evictions and refills all happen, with some
      // fully random rows mixed in
      phase_cap[9] = $urandom_range(0, 127);
      for (int p = 0; p < 10; p++) begin
         set_capacity(phase_cap[p][CAP_W-1:0]);
         if (p < 3) begin
            req_idle_pct = 29;
            rsp_idle_pct = 53;
         end else if (p < 6) begin
            req_idle_pct = 53;
            rsp_idle_pct = 29;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         cap_eff = phase_cap[p];
         if (cap_eff == 0) cap_eff = 1;
         if (cap_eff > SLOT_COUNT) cap_eff = SLOT_COUNT;
         span = cap_eff + 1 + $urandom_range(0, cap_eff);
         // reuse the previous working set now and then to revisit old rows
         if (p == 0 || $urandom_range(3) != 0) pool_base = 16'($urandom);
         for (int n = 0; n < 150; n++) begin
            if ($urandom_range(99) < 15)
               send_row(16'($urandom));
            else
               send_row(pool_base + 16'($urandom_range(0, span - 1)));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (shadow.failures == 0 && shadow.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lrc_pkg.sv
sv/lrc_req_if.sv
sv/lrc_rsp_if.sv
sv/lrc_wb_map.sv
sv/lrc_lookup.sv
sv/lru_row_cache_controller.sv
sim/lru_row_cache_controller_test.sv
